### rtl/file_signature_classifier_macros.svh
// Assertion macros used by the port-level checker of the file signature classifier.
`ifndef FILE_SIGNATURE_CLASSIFIER_MACROS_SVH
`define FILE_SIGNATURE_CLASSIFIER_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define FSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion that is checked during reset as well.
`define FSC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/fsc_pkg.sv
// Types, constants and the signature compare function of the file signature classifier.
package fsc_pkg;

    localparam int HdrDepth = 16;
    localparam int CountMax = 31;

    typedef logic [HdrDepth-1:0][7:0] t_hdr;
    typedef logic [4:0]               t_count;

    typedef enum logic [4:0] {
        K_UNKNOWN = 5'd0,
        K_BMP     = 5'd1,
        K_GIF     = 5'd2,
        K_JP2     = 5'd3,
        K_JPEG    = 5'd4,
        K_PNG     = 5'd5,
        K_WEBP    = 5'd6,
        K_PBM     = 5'd7,
        K_PGM     = 5'd8,
        K_PPM     = 5'd9,
        K_PFM     = 5'd10,
        K_TIFF    = 5'd11,
        K_EXR     = 5'd12,
        K_HDR     = 5'd13,
        K_MKV     = 5'd14,
        K_AVI     = 5'd15,
        K_MOV     = 5'd16,
        K_WMV     = 5'd17,
        K_YUV     = 5'd18,
        K_MP4     = 5'd19,
        K_M4V     = 5'd20
    } t_kind;

    // The pattern is right aligned with its first byte most significant.
    function automatic logic sig_at(input t_hdr hdr, input t_count cnt,
                                    input logic [127:0] pat, input int len,
                                    input int off);
        logic       hit;
        logic [7:0] pb;
        hit = (len + off <= HdrDepth) && (cnt >= 5'(len + off));
        for (int i = 0; i < HdrDepth; i++) begin
            if (i < len) begin
                pb = 8'(pat >> (8 * (len - 1 - i)));
                if (hdr[4'(off + i)] != pb) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

### rtl/fsc_match.sv
// Priority signature matcher over the stored file header.
module fsc_match (
    input  fsc_pkg::t_hdr   i_hdr,
    input  fsc_pkg::t_count i_cnt,
    output fsc_pkg::t_kind  o_kind
);
    import fsc_pkg::*;

    logic riff;

    always_comb begin
        riff = sig_at(i_hdr, i_cnt, 128'("RIFF"), 4, 0);
        if (sig_at(i_hdr, i_cnt, 128'("BM"), 2, 0)) begin
            o_kind = K_BMP;
        end else if (sig_at(i_hdr, i_cnt, 128'("GIF87a"), 6, 0) ||
                     sig_at(i_hdr, i_cnt, 128'("GIF89a"), 6, 0)) begin
            o_kind = K_GIF;
        end else if (sig_at(i_hdr, i_cnt, 128'h0000000c_6a502020_0d0a870a, 12, 0)) begin
            o_kind = K_JP2;
        end else if (sig_at(i_hdr, i_cnt, 128'hffd8ff, 3, 0)) begin
            o_kind = K_JPEG;
        end else if (sig_at(i_hdr, i_cnt, 128'h89504e47, 4, 0)) begin
            o_kind = K_PNG;
        end else if (riff && sig_at(i_hdr, i_cnt, 128'("WEBP"), 4, 8)) begin
            o_kind = K_WEBP;
        end else if (sig_at(i_hdr, i_cnt, 128'("P1"), 2, 0) ||
                     sig_at(i_hdr, i_cnt, 128'("P4"), 2, 0)) begin
            o_kind = K_PBM;
        end else if (sig_at(i_hdr, i_cnt, 128'("P2"), 2, 0) ||
                     sig_at(i_hdr, i_cnt, 128'("P5"), 2, 0)) begin
            o_kind = K_PGM;
        end else if (sig_at(i_hdr, i_cnt, 128'("P3"), 2, 0) ||
                     sig_at(i_hdr, i_cnt, 128'("P6"), 2, 0)) begin
            o_kind = K_PPM;
        end else if (sig_at(i_hdr, i_cnt, 128'("PF"), 2, 0) ||
                     sig_at(i_hdr, i_cnt, 128'("Pf"), 2, 0)) begin
            o_kind = K_PFM;
        end else if (sig_at(i_hdr, i_cnt, 128'h49492a00, 4, 0) ||
                     sig_at(i_hdr, i_cnt, 128'h4949002a, 4, 0)) begin
            o_kind = K_TIFF;
        end else if (sig_at(i_hdr, i_cnt, 128'h762f3101, 4, 0)) begin
            o_kind = K_EXR;
        end else if (sig_at(i_hdr, i_cnt, 128'("#?"), 2, 0)) begin
            o_kind = K_HDR;
        end else if (sig_at(i_hdr, i_cnt, 128'h1a45dfa3, 4, 0)) begin
            o_kind = K_MKV;
        end else if (riff && sig_at(i_hdr, i_cnt, 128'("AVI "), 4, 8)) begin
            o_kind = K_AVI;
        end else if (sig_at(i_hdr, i_cnt, 128'("ftypqt  "), 8, 4)) begin
            o_kind = K_MOV;
        end else if (sig_at(i_hdr, i_cnt,
                            128'h3026b275_8e66cf11_a6d900aa_0062ce6c, 16, 0)) begin
            o_kind = K_WMV;
        end else if (riff && sig_at(i_hdr, i_cnt, 128'("YUVN"), 4, 8)) begin
            o_kind = K_YUV;
        end else if (sig_at(i_hdr, i_cnt, 128'("ftypisom"), 8, 4) ||
                     sig_at(i_hdr, i_cnt, 128'("ftypMSNV"), 8, 4)) begin
            o_kind = K_MP4;
        end else if (sig_at(i_hdr, i_cnt, 128'("ftypmp42"), 8, 4) ||
                     sig_at(i_hdr, i_cnt, 128'("ftypM4V "), 8, 4)) begin
            o_kind = K_M4V;
        end else begin
            o_kind = K_UNKNOWN;
        end
    end

endmodule

### rtl/file_signature_classifier.sv
// Top level of the file signature classifier: header capture, byte count and result register.
// One byte is accepted per cycle while the input is not stalled.
// Accepting the last byte sets the pending flag; the match result is then loaded into the result register.
// The input stalls only while a classification waits behind a stalled, full result register.
// Reset clears the byte count, the pending flag and the result valid; the header is not reset.
module file_signature_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [4:0]           o_file_kind
);
    import fsc_pkg::*;

    t_hdr   r_hdr;
    t_count r_cnt;
    t_count n_cnt;
    t_count r_cls_cnt;
    logic   r_pend;
    logic   r_out_valid;
    t_kind  r_kind;
    t_kind  match_kind;
    logic   in_acc;
    logic   out_load;
    t_count cnt_inc;

    assign out_load   = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cnt_inc    = (r_cnt < 5'(CountMax)) ? r_cnt + 5'd1 : r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc) begin
            n_cnt = i_last_byte ? 5'd0 : cnt_inc;
        end
    end

    fsc_match u_match (
        .i_hdr  (r_hdr),
        .i_cnt  (r_cls_cnt),
        .o_kind (match_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc && i_last_byte) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_cnt < 5'(HdrDepth))) begin
            r_hdr[r_cnt[3:0]] <= i_data_byte;
        end
        if (in_acc && i_last_byte) begin
            r_cls_cnt <= cnt_inc;
        end
        if (out_load) begin
            r_kind <= match_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_file_kind = r_kind;

endmodule

### rtl/fsc_checker.sv
// Port-level checker of the file signature classifier and its bind statement.
`include "file_signature_classifier_macros.svh"

module fsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_file_kind
);
    import fsc_pkg::*;

    `FSC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `FSC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_file_kind))
    `FSC_ASSERT(a_kind_range, i_clk, i_rst_n, o_out_valid |-> o_file_kind <= K_M4V)
    `FSC_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)

endmodule

bind file_signature_classifier fsc_checker u_fsc_checker (.*);

### sim/file_signature_classifier_tb.sv
// Self-checking testbench of the file signature classifier: byte stream driver, result monitor.
`timescale 1ns / 1ps

module file_signature_classifier_tb;

    import fsc_pkg::*;

    localparam int NumSigs    = 28;
    localparam int RandBytes  = 290;
    localparam int CycleLimit = 200000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } t_file_byte;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [4:0] o_file_kind;

    t_file_byte pending_bytes[$];
    t_kind      kind_expected[$];
    logic [7:0] file_buf[$];

    logic [7:0] pred_hdr[HdrDepth];
    int         pred_count = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    file_signature_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_file_kind (o_file_kind)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Signatures in priority order; raw holds the pattern right aligned, first byte highest.
    function automatic void sig_entry(input int sel, output logic [127:0] raw, output int len,
                                      output int off, output bit riff, output t_kind kind);
        off  = 0;
        riff = 1'b0;
        len  = 2;
        raw  = '0;
        kind = K_UNKNOWN;
        case (sel)
            0: begin raw = "BM"; kind = K_BMP; end
            1: begin raw = "GIF87a"; len = 6; kind = K_GIF; end
            2: begin raw = "GIF89a"; len = 6; kind = K_GIF; end
            3: begin raw = 128'h0000000c6a5020200d0a870a; len = 12; kind = K_JP2; end
            4: begin raw = 128'hffd8ff; len = 3; kind = K_JPEG; end
            5: begin raw = 128'h89504e47; len = 4; kind = K_PNG; end
            6: begin raw = "WEBP"; len = 4; off = 8; riff = 1'b1; kind = K_WEBP; end
            7: begin raw = "P1"; kind = K_PBM; end
            8: begin raw = "P4"; kind = K_PBM; end
            9: begin raw = "P2"; kind = K_PGM; end
            10: begin raw = "P5"; kind = K_PGM; end
            11: begin raw = "P3"; kind = K_PPM; end
            12: begin raw = "P6"; kind = K_PPM; end
            13: begin raw = "PF"; kind = K_PFM; end
            14: begin raw = "Pf"; kind = K_PFM; end
            15: begin raw = 128'h49492a00; len = 4; kind = K_TIFF; end
            16: begin raw = 128'h4949002a; len = 4; kind = K_TIFF; end
            17: begin raw = 128'h762f3101; len = 4; kind = K_EXR; end
            18: begin raw = "#?"; kind = K_HDR; end
            19: begin raw = 128'h1a45dfa3; len = 4; kind = K_MKV; end
            20: begin raw = "AVI "; len = 4; off = 8; riff = 1'b1; kind = K_AVI; end
            21: begin raw = "ftypqt  "; len = 8; off = 4; kind = K_MOV; end
            22: begin
                raw  = 128'h3026b2758e66cf11a6d900aa0062ce6c;
                len  = 16;
                kind = K_WMV;
            end
            23: begin raw = "YUVN"; len = 4; off = 8; riff = 1'b1; kind = K_YUV; end
            24: begin raw = "ftypisom"; len = 8; off = 4; kind = K_MP4; end
            25: begin raw = "ftypMSNV"; len = 8; off = 4; kind = K_MP4; end
            26: begin raw = "ftypmp42"; len = 8; off = 4; kind = K_M4V; end
            default: begin raw = "ftypM4V "; len = 8; off = 4; kind = K_M4V; end
        endcase
    endfunction

    function automatic bit header_has(input logic [127:0] raw, input int len, input int off);
        if (pred_count < len + off || len + off > HdrDepth) begin
            return 1'b0;
        end
        for (int i = 0; i < len; i++) begin
            if (pred_hdr[off + i] != raw[8 * (len - 1 - i) +: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_kind classify_header();
        logic [127:0] raw;
        int           len;
        int           off;
        bit           riff;
        t_kind        kind;
        bit           riff_seen;
        riff_seen = header_has(128'("RIFF"), 4, 0);
        for (int sel = 0; sel < NumSigs; sel++) begin
            sig_entry(sel, raw, len, off, riff, kind);
            if (header_has(raw, len, off) && (!riff || riff_seen)) begin
                return kind;
            end
        end
        return K_UNKNOWN;
    endfunction

    function automatic void take_byte(input logic [7:0] data, input logic last);
        if (pred_count < HdrDepth) begin
            pred_hdr[pred_count] = data;
        end
        if (pred_count < CountMax) begin
            pred_count++;
        end
        if (last) begin
            kind_expected.push_back(classify_header());
            pred_count = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Builds a file that carries signature sel, then trims, corrupts or extends it.
    task automatic build_sig_file(input int sel, input int cut, input bit corrupt,
                                  input int extra);
        logic [127:0] raw;
        logic [31:0]  riff_word;
        int           len;
        int           off;
        bit           riff;
        t_kind        kind;
        int           pos;
        sig_entry(sel, raw, len, off, riff, kind);
        riff_word = "RIFF";
        file_buf.delete();
        for (int i = 0; i < off; i++) begin
            if (riff && i < 4) begin
                file_buf.push_back(riff_word[8 * (3 - i) +: 8]);
            end else begin
                file_buf.push_back(8'($urandom));
            end
        end
        for (int i = 0; i < len; i++) begin
            file_buf.push_back(raw[8 * (len - 1 - i) +: 8]);
        end
        if (corrupt) begin
            pos = $urandom_range(0, off + len - 1);
            file_buf[pos] = file_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < extra; i++) begin
            file_buf.push_back(8'($urandom));
        end
        for (int i = 0; i < cut && file_buf.size() > 1; i++) begin
            void'(file_buf.pop_back());
        end
    endtask

    task automatic build_noise_file(input int len);
        file_buf.delete();
        for (int i = 0; i < len; i++) begin
            file_buf.push_back(8'($urandom));
        end
    endtask

    task automatic queue_file(input bit drain);
        t_file_byte item;
        for (int i = 0; i < file_buf.size(); i++) begin
            item.data  = file_buf[i];
            item.last  = (i == file_buf.size() - 1);
            item.drain = drain && (i == 0);
            pending_bytes.push_back(item);
        end
    endtask

    initial begin
        int rand_count;
        int pick;
        file_buf = '{8'h42};
        queue_file(1'b0);
        for (int sel = 0; sel < NumSigs; sel++) begin
            build_sig_file(sel, 0, 1'b0, 0);
            queue_file(1'b0);
        end
        build_sig_file(3, 1, 1'b0, 0);
        queue_file(1'b0);
        build_sig_file(22, 1, 1'b0, 0);
        queue_file(1'b0);
        build_sig_file(6, 4, 1'b0, 0);
        queue_file(1'b0);
        build_sig_file(26, 0, 1'b0, 30);
        queue_file(1'b0);
        file_buf = '{8'hff, 8'h00, 8'hff, 8'h00};
        queue_file(1'b0);
        rand_count = 0;
        while (rand_count < RandBytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                build_sig_file($urandom_range(0, NumSigs - 1), 0, $urandom_range(0, 9) == 0,
                               ($urandom_range(0, 9) == 0) ? $urandom_range(16, 30)
                                                           : $urandom_range(0, 6));
            end else if (pick < 85) begin
                build_sig_file($urandom_range(0, NumSigs - 1), $urandom_range(1, 15), 1'b0, 0);
            end else begin
                build_noise_file($urandom_range(1, 40));
            end
            rand_count += file_buf.size();
            queue_file(rand_count == file_buf.size() || $urandom_range(0, 19) == 0);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (kind_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && kind_expected.size() == 0) begin
            $display("PASS file_signature_classifier");
        end else begin
            $display("FAIL file_signature_classifier");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive_bytes
        static int burst_left = 1;
        static int gap_left = 0;
        t_file_byte item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                take_byte(i_data_byte, i_last_byte);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].drain && kind_expected.size() != 0)) begin
                    item = pending_bytes.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= item.data;
                    i_last_byte <= item.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_kinds
        static int stall_left = 0;
        static int stall_mode = 0;
        t_kind want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (kind_expected.size() == 0) begin
                    report_mismatch("unexpected file kind", o_file_kind, -1);
                end else begin
                    want = kind_expected.pop_front();
                    if (o_file_kind !== want) begin
                        report_mismatch("file_kind", o_file_kind, want);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_left = $urandom_range(8, 48);
                stall_mode = $urandom_range(0, 2);
            end
            stall_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL file_signature_classifier");
            $finish;
        end
    end

endmodule

### file_signature_classifier.f
+incdir+rtl
rtl/fsc_pkg.sv
rtl/fsc_match.sv
rtl/file_signature_classifier.sv
rtl/fsc_checker.sv
sim/file_signature_classifier_tb.sv
